@@ rtl/skvt_pkg.sv @@
// Shared types, codes and constants for the sorted key/value table.
package skvt_pkg;

	localparam int DEF_CAPACITY = 256;

	localparam logic [3:0] FN_INSERT       = 4'd0;
	localparam logic [3:0] FN_GET          = 4'd1;
	localparam logic [3:0] FN_REMOVE_KEY   = 4'd2;
	localparam logic [3:0] FN_REMOVE_AT    = 4'd3;
	localparam logic [3:0] FN_REMOVE_RANGE = 4'd4;
	localparam logic [3:0] FN_KEY_AT       = 4'd5;
	localparam logic [3:0] FN_VALUE_AT     = 4'd6;
	localparam logic [3:0] FN_SET_VALUE    = 4'd7;
	localparam logic [3:0] FN_INDEX_KEY    = 4'd8;
	localparam logic [3:0] FN_INDEX_VALUE  = 4'd9;
	localparam logic [3:0] FN_CLEAR        = 4'd10;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_RANGE     = 3'd3;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_SRCH_RD, S_SRCH_CMP, S_UP_RD, S_UP_WR, S_RD, S_CAP,
		S_DN_INIT, S_DN_RD, S_DN_WR, S_SCAN_RD, S_SCAN_CMP, S_FINISH
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_STATUS, OP_SRCH_RD, OP_SRCH_CMP, OP_OVERWRITE, OP_SET_IDX,
		OP_UP_INIT, OP_UP_RD, OP_UP_WR, OP_INS, OP_RD_AT, OP_CAP_VAL, OP_CAP_KEY,
		OP_DN_INIT, OP_DN_RD, OP_DN_WR, OP_DN_END, OP_WR_VAL, OP_SCAN_INIT, OP_SCAN_RD,
		OP_SCAN_CMP, OP_CLEAR, OP_PUBLISH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] func;
		logic       srch_open;
		logic       found;
		logic       full;
		logic       empty;
		logic       pos_range;
		logic       batch_zero;
		logic       up_more;
		logic       dn_more;
		logic       val_eq;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ rtl/sorted_key_value_table_unit.sv @@
// Top level of the sorted key/value table.
// Keeps up to CAPACITY entries (signed 32-bit key, 64-bit value) in ascending key order.
// Input channel: in_valid/in_stall with func, key, value, position, batch_count; one beat
// is one command. Output channel: out_valid/out_stall with status, found_index, key_out,
// value_out, removed_count, entry_count; every command yields exactly one result beat.
// Commands run one at a time. Each memory step is a read then a compare or write, on the
// single read and single write port of the stores. Memory steps by command:
//   lookups by key: a binary search over the stored keys,
//   insert: search, then every entry above the slot moves up by one,
//   removal: the entries above the removed span move down, after the search by key,
//   index of value: a scan upward from index 0 to the first match,
//   other index commands: one read or write of the entry; clear: none.
// A new command is taken while the previous result still waits; the finished result
// then holds until the output register is free. A stalled result beat holds unchanged.
// Reset empties the table at once; the stores need no clearing pass.
module sorted_key_value_table_unit
	import skvt_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         func,
	input  logic signed [31:0] key,
	input  logic [63:0]        value,
	input  logic [9:0]         position,
	input  logic [9:0]         batch_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [8:0]  found_index,
	output logic signed [31:0] key_out,
	output logic [63:0]        value_out,
	output logic [8:0]         removed_count,
	output logic [8:0]         entry_count
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	skvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	skvt_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.key           (key),
		.value         (value),
		.position      (position),
		.batch_count   (batch_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found_index   (found_index),
		.key_out       (key_out),
		.value_out     (value_out),
		.removed_count (removed_count),
		.entry_count   (entry_count)
	);

endmodule

@@ rtl/skvt_ctrl.sv @@
// Command sequencer for the sorted key/value table.
module skvt_ctrl
	import skvt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.code = ST_OK;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				case (stat.func)
					FN_INSERT, FN_GET, FN_REMOVE_KEY, FN_INDEX_KEY: state_d = S_SRCH_RD;
					FN_REMOVE_AT, FN_KEY_AT: begin
						if (stat.pos_range) begin
							cmd.op = OP_STATUS; cmd.code = ST_RANGE;
						end else begin
							state_d = S_RD;
						end
					end
					FN_REMOVE_RANGE: begin
						if (stat.empty) begin
							cmd.op = OP_STATUS; cmd.code = ST_EMPTY;
						end else if (stat.pos_range) begin
							cmd.op = OP_STATUS; cmd.code = ST_RANGE;
						end else if (stat.batch_zero) begin
							cmd.op = OP_STATUS; cmd.code = ST_BAD_SIZE;
						end else begin
							state_d = S_DN_INIT;
						end
					end
					FN_VALUE_AT, FN_SET_VALUE: begin
						if (stat.empty) begin
							cmd.op = OP_STATUS; cmd.code = ST_EMPTY;
						end else if (stat.pos_range) begin
							cmd.op = OP_STATUS; cmd.code = ST_RANGE;
						end else if (stat.func == FN_VALUE_AT) begin
							state_d = S_RD;
						end else begin
							cmd.op = OP_WR_VAL;
						end
					end
					FN_INDEX_VALUE: begin
						cmd.op  = OP_SCAN_INIT;
						state_d = S_SCAN_RD;
					end
					FN_CLEAR: cmd.op = OP_CLEAR;
					default: ;
				endcase
			end
			S_SRCH_RD: begin
				if (stat.srch_open) begin
					cmd.op  = OP_SRCH_RD;
					state_d = S_SRCH_CMP;
				end else if (stat.found) begin
					state_d = S_FINISH;
					case (stat.func)
						FN_INSERT:    cmd.op = OP_OVERWRITE;
						FN_INDEX_KEY: cmd.op = OP_SET_IDX;
						default:      state_d = S_RD;
					endcase
				end else if (stat.func == FN_INSERT) begin
					if (stat.full) begin
						cmd.op = OP_STATUS; cmd.code = ST_FULL;
						state_d = S_FINISH;
					end else begin
						cmd.op  = OP_UP_INIT;
						state_d = S_UP_RD;
					end
				end else begin
					cmd.op = OP_STATUS; cmd.code = ST_NOT_FOUND;
					state_d = S_FINISH;
				end
			end
			S_SRCH_CMP: begin
				cmd.op  = OP_SRCH_CMP;
				state_d = S_SRCH_RD;
			end
			S_UP_RD: begin
				if (stat.up_more) begin
					cmd.op  = OP_UP_RD;
					state_d = S_UP_WR;
				end else begin
					cmd.op  = OP_INS;
					state_d = S_FINISH;
				end
			end
			S_UP_WR: begin
				cmd.op  = OP_UP_WR;
				state_d = S_UP_RD;
			end
			S_RD: begin
				cmd.op  = OP_RD_AT;
				state_d = S_CAP;
			end
			S_CAP: begin
				if (stat.func == FN_KEY_AT) begin
					cmd.op  = OP_CAP_KEY;
					state_d = S_FINISH;
				end else begin
					cmd.op = OP_CAP_VAL;
					if (stat.func == FN_GET || stat.func == FN_VALUE_AT) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_DN_INIT;
					end
				end
			end
			S_DN_INIT: begin
				cmd.op  = OP_DN_INIT;
				state_d = S_DN_RD;
			end
			S_DN_RD: begin
				if (stat.dn_more) begin
					cmd.op  = OP_DN_RD;
					state_d = S_DN_WR;
				end else begin
					cmd.op  = OP_DN_END;
					state_d = S_FINISH;
				end
			end
			S_DN_WR: begin
				cmd.op  = OP_DN_WR;
				state_d = S_DN_RD;
			end
			S_SCAN_RD: begin
				if (stat.dn_more) begin
					cmd.op  = OP_SCAN_RD;
					state_d = S_SCAN_CMP;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN_CMP: begin
				cmd.op  = OP_SCAN_CMP;
				state_d = stat.val_eq ? S_FINISH : S_SCAN_RD;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.op  = OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/skvt_dp.sv @@
// Datapath of the sorted key/value table: stores, search pointers and result registers.
module skvt_dp
	import skvt_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [3:0]          func,
	input  logic signed [31:0]  key,
	input  logic [63:0]         value,
	input  logic [9:0]          position,
	input  logic [9:0]          batch_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic signed [8:0]   found_index,
	output logic signed [31:0]  key_out,
	output logic [63:0]         value_out,
	output logic [8:0]          removed_count,
	output logic [8:0]          entry_count
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 10) ? CW : 10;

	logic [31:0] key_mem [CAPACITY];
	logic [63:0] val_mem [CAPACITY];

	logic [3:0]         func_q;
	logic signed [31:0] key_q;
	logic [63:0]        value_q;
	logic [9:0]         pos_q;
	logic [9:0]         batch_q;

	logic [CW-1:0] count_q, lo_q, hi_q, ptr_q, n_q;
	logic [IW-1:0] mid_q;
	logic          found_q;
	logic [31:0]   rd_key_q;
	logic [63:0]   rd_val_q;

	logic [2:0]    st_q;
	logic          idx_none_q;
	logic [IW-1:0] idx_q;
	logic [31:0]   kout_q;
	logic [63:0]   vout_q;
	logic [CW-1:0] rem_q;

	logic          out_valid_q;

	logic          we, re;
	logic [IW-1:0] wa, ra, tgt, mid;
	logic [31:0]   wk;
	logic [63:0]   wv;
	logic [CW-1:0] up_src, dn_dst, avail, n_range;
	logic [CW:0]   mid_sum;
	logic          key_we;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = IW'(mid_sum >> 1);
	assign tgt     = (func_q == FN_GET || func_q == FN_REMOVE_KEY) ? lo_q[IW-1:0] : IW'(pos_q);
	assign up_src  = ptr_q - CW'(1);
	assign dn_dst  = ptr_q - n_q;
	assign avail   = count_q - CW'(pos_q);
	assign n_range = (PW'(batch_q) < PW'(avail)) ? CW'(batch_q) : avail;

	assign stat.func       = func_q;
	assign stat.srch_open  = (lo_q < hi_q) && !found_q;
	assign stat.found      = found_q;
	assign stat.full       = (count_q == CW'(CAPACITY));
	assign stat.empty      = (count_q == '0);
	assign stat.pos_range  = (PW'(pos_q) >= PW'(count_q));
	assign stat.batch_zero = (batch_q == '0);
	assign stat.up_more    = (ptr_q > lo_q);
	assign stat.dn_more    = (ptr_q < count_q);
	assign stat.val_eq     = (rd_val_q == value_q);
	assign stat.out_free   = !out_valid_q || !out_stall;

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = tgt;
		ra = tgt;
		wk = rd_key_q;
		wv = rd_val_q;
		case (cmd.op)
			OP_SRCH_RD: begin re = 1'b1; ra = mid; end
			OP_OVERWRITE: begin
				we = 1'b1; wa = lo_q[IW-1:0]; wk = key_q; wv = value_q;
			end
			OP_UP_RD: begin re = 1'b1; ra = up_src[IW-1:0]; end
			OP_UP_WR: begin we = 1'b1; wa = ptr_q[IW-1:0]; end
			OP_INS: begin
				we = 1'b1; wa = lo_q[IW-1:0]; wk = key_q; wv = value_q;
			end
			OP_RD_AT: re = 1'b1;
			OP_DN_RD, OP_SCAN_RD: begin re = 1'b1; ra = ptr_q[IW-1:0]; end
			OP_DN_WR: begin we = 1'b1; wa = dn_dst[IW-1:0]; end
			OP_WR_VAL: begin
				we = 1'b1; wv = value_q;
			end
			default: ;
		endcase
	end

	// set value at keeps the key: write the value store only
	assign key_we = we && (cmd.op != OP_WR_VAL);

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wa] <= wk;
		end
		if (we) begin
			val_mem[wa] <= wv;
		end
		if (re) begin
			rd_key_q <= key_mem[ra];
			rd_val_q <= val_mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_PUBLISH) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_INS:     count_q <= count_q + CW'(1);
				OP_DN_END:  count_q <= count_q - n_q;
				OP_CLEAR:   count_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q     <= func;
				key_q      <= key;
				value_q    <= value;
				pos_q      <= position;
				batch_q    <= batch_count;
				lo_q       <= '0;
				hi_q       <= count_q;
				found_q    <= 1'b0;
				st_q       <= ST_OK;
				idx_none_q <= 1'b1;
				idx_q      <= '0;
				kout_q     <= '0;
				vout_q     <= '0;
				rem_q      <= '0;
			end
			OP_STATUS: st_q <= cmd.code;
			OP_SRCH_RD: mid_q <= mid;
			OP_SRCH_CMP: begin
				if ($signed(rd_key_q) < key_q) begin
					lo_q <= CW'(mid_q) + CW'(1);
				end else if ($signed(rd_key_q) == key_q) begin
					lo_q    <= CW'(mid_q);
					found_q <= 1'b1;
				end else begin
					hi_q <= CW'(mid_q);
				end
			end
			OP_OVERWRITE, OP_SET_IDX, OP_INS: begin
				idx_none_q <= 1'b0;
				idx_q      <= lo_q[IW-1:0];
			end
			OP_UP_INIT: ptr_q <= count_q;
			OP_UP_WR:   ptr_q <= up_src;
			OP_CAP_VAL: begin
				vout_q <= rd_val_q; idx_none_q <= 1'b0; idx_q <= tgt;
			end
			OP_CAP_KEY: begin
				kout_q <= rd_key_q; idx_none_q <= 1'b0; idx_q <= tgt;
			end
			OP_DN_INIT: begin
				n_q        <= (func_q == FN_REMOVE_RANGE) ? n_range : CW'(1);
				rem_q      <= (func_q == FN_REMOVE_RANGE) ? n_range : CW'(1);
				ptr_q      <= CW'(tgt) + ((func_q == FN_REMOVE_RANGE) ? n_range : CW'(1));
				idx_none_q <= 1'b0;
				idx_q      <= tgt;
			end
			OP_DN_WR: ptr_q <= ptr_q + CW'(1);
			OP_WR_VAL: begin
				idx_none_q <= 1'b0; idx_q <= tgt;
			end
			OP_SCAN_INIT: begin
				ptr_q <= '0; st_q <= ST_NOT_FOUND;
			end
			OP_SCAN_CMP: begin
				if (rd_val_q == value_q) begin
					st_q <= ST_OK; idx_none_q <= 1'b0; idx_q <= ptr_q[IW-1:0];
				end else begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			OP_PUBLISH: begin
				status        <= st_q;
				found_index   <= idx_none_q ? '1 : 9'(idx_q);
				key_out       <= kout_q;
				value_out     <= vout_q;
				removed_count <= 9'(rem_q);
				entry_count   <= 9'(count_q);
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/skvt_checker.sv @@
// Port-level checks for the sorted key/value table, bound to the top level.
module skvt_checker
	import skvt_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [8:0]  removed_count,
	input logic [8:0]  entry_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
		else $error("result beat changed while stalled");

	a_fail_no_removal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> removed_count == 9'd0)
		else $error("entries removed on a failed command");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == 9'(CAPACITY))
		else $error("full reported below capacity");

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second command taken while one is in flight");

endmodule

bind sorted_key_value_table_unit skvt_checker #(.CAPACITY(CAPACITY)) u_skvt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.removed_count (removed_count),
	.entry_count   (entry_count)
);
